/* src/tgec_pkg.sv */
// Shared types and constants for the touch gesture event classifier.
package tgec_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [3:0] {
      EV_NONE          = 4'd0,
      EV_TOUCHED       = 4'd1,
      EV_MOVE          = 4'd2,
      EV_LONG          = 4'd3,
      EV_AUTO_FAST     = 4'd4,
      EV_AUTO          = 4'd5,
      EV_RELEASED_LONG = 4'd6,
      EV_SHORT         = 4'd7,
      EV_RELEASED      = 4'd8
   } event_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCREEN_MAX_X      = 3'd0,
      REG_SCREEN_MAX_Y      = 3'd1,
      REG_INVERT_Y          = 3'd2,
      REG_LONG_PRESS_TICKS  = 3'd3,
      REG_AUTO_REPEAT_TICKS = 3'd4,
      REG_FAST_REPEAT_MARKS = 3'd5,
      REG_RELEASE_TICKS     = 3'd6,
      REG_SLEEP_TICKS       = 3'd7
   } csr_index_type;

   typedef struct packed {
      event_code_type     first_code;
      logic               two_results;
      logic signed [11:0] x;
      logic [10:0]        y;
      logic               dimmed;
   } tick_record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* src/tgec_queue.sv */
// Small register queue that carries tick records from the front to the back.
module tgec_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tgec_pkg::tick_record_type push_data,
   input  logic                      pop,
   output tgec_pkg::tick_record_type head_data,
   output tgec_pkg::queue_status_type status
);

   tgec_pkg::tick_record_type             mem_ff [tgec_pkg::QUEUE_DEPTH];
   logic [tgec_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tgec_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tgec_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;

   localparam logic [tgec_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      tgec_pkg::QUEUE_PTR_W'(tgec_pkg::QUEUE_DEPTH - 1);
   localparam logic [tgec_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      tgec_pkg::QUEUE_CNT_W'(tgec_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/tgec_front.sv */
// Front end: configuration registers, tick classification and gesture state.
module tgec_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_touched,
   input  logic signed [11:0]                   req_pos_x,
   input  logic signed [11:0]                   req_pos_y,
   input  logic                                 req_monitor_page,
   input  logic                                 csr_write_enable,
   input  logic [tgec_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tgec_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  tgec_pkg::queue_status_type           queue_status,
   output logic                                 push,
   output tgec_pkg::tick_record_type            push_data
);

   logic [10:0] max_x_ff, max_y_ff;
   logic        invert_y_ff;
   logic [15:0] long_press_ff, auto_repeat_ff, sleep_ticks_ff;
   logic [47:0] fast_marks_ff;
   logic [7:0]  release_ticks_ff;

   logic [7:0]         countdown_ff, countdown_in;
   logic [15:0]        hold_ff, hold_in;
   logic               long_seen_ff, long_seen_in;
   logic [15:0]        idle_ff, idle_in;
   logic               dimmed_ff, dimmed_in;
   logic signed [11:0] held_x_ff, held_x_in;
   logic [10:0]        held_y_ff, held_y_in;

   logic [15:0]             hold_inc;
   logic [15:0]             idle_inc;
   logic [7:0]              countdown_dec;
   logic                    fast_hit;
   logic                    released;
   logic [10:0]             y_clamped;
   tgec_pkg::event_code_type code;
   logic                    accept;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;

   assign hold_inc      = hold_ff + 16'd1;
   assign idle_inc      = idle_ff + 16'd1;
   assign countdown_dec = countdown_ff - 8'd1;

   always_comb begin
      fast_hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (fast_marks_ff[16*k +: 16] != 16'd0 && hold_inc == fast_marks_ff[16*k +: 16]) begin
            fast_hit = 1'b1;
         end
      end
   end

   always_comb begin
      countdown_in = countdown_ff;
      hold_in      = hold_ff;
      long_seen_in = long_seen_ff;
      idle_in      = idle_ff;
      dimmed_in    = dimmed_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      released     = 1'b0;
      code         = tgec_pkg::EV_NONE;
      y_clamped    = '0;

      if (req_touched) begin
         dimmed_in = 1'b0;
         idle_in   = '0;
         if (req_pos_y[11]) begin
            y_clamped = '0;
         end else if (req_pos_y[10:0] > max_y_ff) begin
            y_clamped = max_y_ff;
         end else begin
            y_clamped = req_pos_y[10:0];
         end
         held_y_in = invert_y_ff ? (max_y_ff - y_clamped) : y_clamped;
         if ($signed({req_pos_x[11], req_pos_x}) > $signed({2'b00, max_x_ff})) begin
            held_x_in = $signed({1'b0, max_x_ff});
         end else begin
            held_x_in = req_pos_x;
         end

         if (countdown_ff != 8'd0) begin
            code    = tgec_pkg::EV_MOVE;
            hold_in = hold_inc;
            if (!long_seen_ff && hold_inc > long_press_ff) begin
               long_seen_in = 1'b1;
               code         = tgec_pkg::EV_LONG;
            end
            if (fast_hit) begin
               code = tgec_pkg::EV_AUTO_FAST;
            end
            if (hold_inc == auto_repeat_ff) begin
               hold_in = '0;
               code    = tgec_pkg::EV_AUTO;
            end
         end else begin
            code = tgec_pkg::EV_TOUCHED;
         end
         countdown_in = release_ticks_ff;
      end else begin
         if (countdown_ff != 8'd0) begin
            countdown_in = countdown_dec;
            if (countdown_dec == 8'd0) begin
               released     = 1'b1;
               code         = long_seen_ff ? tgec_pkg::EV_RELEASED_LONG : tgec_pkg::EV_SHORT;
               long_seen_in = 1'b0;
               hold_in      = '0;
            end
         end
         if (idle_ff < sleep_ticks_ff && !req_monitor_page) begin
            idle_in = idle_inc;
            if (idle_inc == sleep_ticks_ff) begin
               dimmed_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      push_data.first_code  = code;
      push_data.two_results = released;
      push_data.x           = held_x_in;
      push_data.y           = held_y_in;
      push_data.dimmed      = dimmed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff         <= 11'd319;
         max_y_ff         <= 11'd239;
         invert_y_ff      <= 1'b0;
         long_press_ff    <= 16'd25;
         auto_repeat_ff   <= 16'd100;
         fast_marks_ff    <= '0;
         release_ticks_ff <= 8'd3;
         sleep_ticks_ff   <= 16'd3000;
      end else if (csr_write_enable) begin
         unique case (tgec_pkg::csr_index_type'(csr_index))
            tgec_pkg::REG_SCREEN_MAX_X:      max_x_ff         <= csr_write_data[10:0];
            tgec_pkg::REG_SCREEN_MAX_Y:      max_y_ff         <= csr_write_data[10:0];
            tgec_pkg::REG_INVERT_Y:          invert_y_ff      <= csr_write_data[0];
            tgec_pkg::REG_LONG_PRESS_TICKS:  long_press_ff    <= csr_write_data[15:0];
            tgec_pkg::REG_AUTO_REPEAT_TICKS: auto_repeat_ff   <= csr_write_data[15:0];
            tgec_pkg::REG_FAST_REPEAT_MARKS: fast_marks_ff    <= csr_write_data[47:0];
            tgec_pkg::REG_RELEASE_TICKS:     release_ticks_ff <= csr_write_data[7:0];
            tgec_pkg::REG_SLEEP_TICKS:       sleep_ticks_ff   <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         hold_ff      <= '0;
         long_seen_ff <= 1'b0;
         idle_ff      <= '0;
         dimmed_ff    <= 1'b0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
      end else if (accept) begin
         countdown_ff <= countdown_in;
         hold_ff      <= hold_in;
         long_seen_ff <= long_seen_in;
         idle_ff      <= idle_in;
         dimmed_ff    <= dimmed_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
      end
   end

endmodule

/* src/tgec_back.sv */
// Back end: expands each tick record into one or two result transactions.
module tgec_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tgec_pkg::tick_record_type   head_data,
   input  tgec_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_event_code,
   output logic signed [11:0]          rsp_event_x,
   output logic [10:0]                 rsp_event_y,
   output logic                        rsp_backlight_dimmed,
   output logic                        rsp_last_of_tick
);

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'b01,
      PHASE_SECOND = 2'b10
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      take;

   assign rsp_valid            = !queue_status.empty;
   assign take                 = rsp_valid && !rsp_stall;
   assign pop                  = take && rsp_last_of_tick;
   assign rsp_event_x          = head_data.x;
   assign rsp_event_y          = head_data.y;
   assign rsp_backlight_dimmed = head_data.dimmed;

   always_comb begin
      unique case (phase_ff)
         PHASE_FIRST: begin
            rsp_event_code   = head_data.first_code;
            rsp_last_of_tick = !head_data.two_results;
         end
         PHASE_SECOND: begin
            rsp_event_code   = tgec_pkg::EV_RELEASED;
            rsp_last_of_tick = 1'b1;
         end
         default: begin
            rsp_event_code   = head_data.first_code;
            rsp_last_of_tick = !head_data.two_results;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         phase_in = rsp_last_of_tick ? PHASE_FIRST : PHASE_SECOND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

/* src/touch_gesture_event_classifier.sv */
// Top level of the touch gesture event classifier.
// A tick accepted by the front end is queued; its first result shows once earlier
// records are taken. Throughput: one tick per cycle while results are taken; a
// release tick gives two results, so the one-result-per-cycle port sets the rate.
// A four-entry queue between classifier and result sequencer absorbs output stalls.
// Reset (synchronous): gesture state and queue clear, registers return to defaults.
module touch_gesture_event_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_touched,
   input  logic signed [11:0]               req_pos_x,
   input  logic signed [11:0]               req_pos_y,
   input  logic                             req_monitor_page,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [3:0]                       rsp_event_code,
   output logic signed [11:0]               rsp_event_x,
   output logic [10:0]                      rsp_event_y,
   output logic                             rsp_backlight_dimmed,
   output logic                             rsp_last_of_tick,
   input  logic                             csr_write_enable,
   input  logic [tgec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgec_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   tgec_pkg::queue_status_type queue_status;
   tgec_pkg::tick_record_type  push_data;
   tgec_pkg::tick_record_type  head_data;
   logic                       push;
   logic                       pop;

   tgec_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_touched      (req_touched),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_monitor_page (req_monitor_page),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .push             (push),
      .push_data        (push_data)
   );

   tgec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   tgec_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_data            (head_data),
      .queue_status         (queue_status),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_event_x          (rsp_event_x),
      .rsp_event_y          (rsp_event_y),
      .rsp_backlight_dimmed (rsp_backlight_dimmed),
      .rsp_last_of_tick     (rsp_last_of_tick)
   );

endmodule

/* src/tgec_checker.sv */
// Port-level assertions for the touch gesture event classifier, with its bind.
module tgec_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [3:0]        rsp_event_code,
   input logic signed [11:0] rsp_event_x,
   input logic [10:0]       rsp_event_y,
   input logic              rsp_backlight_dimmed,
   input logic              rsp_last_of_tick
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_event_x) && $stable(rsp_event_y) && $stable(rsp_last_of_tick))
      else $error("Stalled result transaction changed.");

   a_release_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_tick |=>
         rsp_valid && rsp_last_of_tick && rsp_event_code == tgec_pkg::EV_RELEASED)
      else $error("First half of a release was not followed by the released event.");

   a_release_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == tgec_pkg::EV_SHORT
         || rsp_event_code == tgec_pkg::EV_RELEASED_LONG) |-> !rsp_last_of_tick)
      else $error("Release classification was marked as the last result of a tick.");

   a_touch_wakes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == tgec_pkg::EV_TOUCHED
         || rsp_event_code == tgec_pkg::EV_MOVE || rsp_event_code == tgec_pkg::EV_LONG
         || rsp_event_code == tgec_pkg::EV_AUTO_FAST
         || rsp_event_code == tgec_pkg::EV_AUTO) |-> !rsp_backlight_dimmed)
      else $error("Touch event reported with the backlight dimmed.");

endmodule

bind touch_gesture_event_classifier tgec_checker u_tgec_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_event_code       (rsp_event_code),
   .rsp_event_x          (rsp_event_x),
   .rsp_event_y          (rsp_event_y),
   .rsp_backlight_dimmed (rsp_backlight_dimmed),
   .rsp_last_of_tick     (rsp_last_of_tick)
);
